// ===== sv/ldv_pkg.sv =====
// Shared types, constants and fixed-point helpers for the lens distortion vertex block.
// No dependencies; the other files of the block, ldv_ram apart, refer to this package by scoped names.
`timescale 1ns / 1ps

package ldv_pkg;

   // Knot table geometry.
   localparam int MAX_KNOTS = 16;
   localparam int KNOT_AW   = $clog2(MAX_KNOTS);
   localparam int KCOUNT_W  = 5;
   localparam int KCOUNT_MIN = 3;

   // Reset values of the configuration registers.
   localparam logic signed [23:0] HSHIFT_RESET      = 24'sd0;
   localparam logic signed [23:0] TAN_SCALE_X_RESET = 24'sd48891;
   localparam logic signed [23:0] TAN_SCALE_Y_RESET = 24'sd55039;
   localparam logic [KCOUNT_W-1:0] KNOT_COUNT_RESET = 5'd11;
   localparam logic signed [23:0] RED_OFFSET_RESET  = -24'sd1049;
   localparam logic signed [23:0] RED_SLOPE_RESET   = 24'sd0;
   localparam logic signed [23:0] BLUE_OFFSET_RESET = 24'sd1573;
   localparam logic signed [23:0] BLUE_SLOPE_RESET  = 24'sd0;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_HSHIFT      = 3'd0,
      CSR_TAN_SCALE_X = 3'd1,
      CSR_TAN_SCALE_Y = 3'd2,
      CSR_KNOT_COUNT  = 3'd3,
      CSR_RED_OFFSET  = 3'd4,
      CSR_RED_SLOPE   = 3'd5,
      CSR_BLUE_OFFSET = 3'd6,
      CSR_BLUE_SLOPE  = 3'd7
   } csr_index_type;

   typedef logic signed [23:0] q16_type;

   // Front-end configuration.
   typedef struct packed {
      q16_type hshift;
      q16_type tan_scale_x;
      q16_type tan_scale_y;
   } front_cfg_type;

   // Chromatic configuration.
   typedef struct packed {
      q16_type red_offset;
      q16_type red_slope;
      q16_type blue_offset;
      q16_type blue_slope;
   } chroma_cfg_type;

   // A knot write riding along the front end.
   typedef struct packed {
      logic                 op;
      logic [KNOT_AW-1:0]   kidx;
      q16_type              kval;
   } knot_cmd_type;

   typedef struct packed {
      q16_type tx;
      q16_type ty;
      q16_type rsq;
   } coord_type;

   typedef struct packed {
      knot_cmd_type cmd;
      coord_type    crd;
   } tan_item_type;

   typedef struct packed {
      coord_type crd;
      q16_type   scale;
   } scale_item_type;

   typedef struct packed {
      q16_type tx;
      q16_type ty;
      q16_type cs_red;
      q16_type cs_green;
      q16_type cs_blue;
   } chan_item_type;

   // Round half up, then drop 16 fraction bits.
   function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   // Round half up, then drop 32 fraction bits.
   function automatic logic signed [63:0] rnd32(input logic signed [63:0] x);
      return (x + 64'sd2147483648) >>> 32;
   endfunction

   // Clamp to the signed 24-bit range.
   function automatic q16_type sat24(input logic signed [63:0] x);
      if (x > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (x < -64'sd8388608) begin
         return 24'sh800000;
      end
      return x[23:0];
   endfunction

endpackage

// ===== sv/lens_distortion_vertex.sv =====
// An accepted evaluate request passes ldv_tangent, ldv_spline, ldv_chroma and the output stages to rsp_.
// Throughput: one request per cycle while rsp_tready holds; knot writes and vertices share the pipeline.
// Knot writes produce no result and take effect in request order.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// The knot table contents are not cleared by reset.
// Depends on ldv_pkg, ldv_tangent, ldv_spline, ldv_chroma and ldv_ram.
`timescale 1ns / 1ps

module lens_distortion_vertex (
   input  logic         clock,
   input  logic         reset,
   // tdata: eye_select[0], coord_u[24:1], coord_v[48:25], knot_index[52:49],
   //        knot_value[76:53], zero fill [79:77]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   // tuser: operation[0]
   input  logic [0:0]   req_tuser,
   // tdata: red_x, red_y, green_x, green_y, blue_x, blue_y, 24 bits each
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);

   localparam int NS = 2;
   localparam int AW = ldv_pkg::KNOT_AW;

   ldv_pkg::q16_type hshift_ff, tsx_ff, tsy_ff;
   ldv_pkg::q16_type roff_ff, rslope_ff, boff_ff, bslope_ff;
   logic [ldv_pkg::KCOUNT_W-1:0] kcount_ff;
   logic [AW-1:0] nm1;

   ldv_pkg::front_cfg_type  front_cfg;
   ldv_pkg::chroma_cfg_type chroma_cfg;
   ldv_pkg::tan_item_type   tan_item;
   ldv_pkg::scale_item_type scale_item;
   ldv_pkg::chan_item_type  chan_item;
   logic tan_valid, tan_ready, scale_valid, scale_ready, chan_valid, chan_ready;

   logic [NS:1]   v_ff;
   logic [NS:1]   v_in;
   logic [NS+1:1] en;
   logic signed [47:0] prod_ff [6];
   ldv_pkg::q16_type   res_ff [6];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hshift_ff <= ldv_pkg::HSHIFT_RESET;
         tsx_ff    <= ldv_pkg::TAN_SCALE_X_RESET;
         tsy_ff    <= ldv_pkg::TAN_SCALE_Y_RESET;
         kcount_ff <= ldv_pkg::KNOT_COUNT_RESET;
         roff_ff   <= ldv_pkg::RED_OFFSET_RESET;
         rslope_ff <= ldv_pkg::RED_SLOPE_RESET;
         boff_ff   <= ldv_pkg::BLUE_OFFSET_RESET;
         bslope_ff <= ldv_pkg::BLUE_SLOPE_RESET;
      end else if (csr_we) begin
         unique case (ldv_pkg::csr_index_type'(csr_index))
            ldv_pkg::CSR_HSHIFT:      hshift_ff <= csr_wdata;
            ldv_pkg::CSR_TAN_SCALE_X: tsx_ff    <= csr_wdata;
            ldv_pkg::CSR_TAN_SCALE_Y: tsy_ff    <= csr_wdata;
            ldv_pkg::CSR_KNOT_COUNT:  kcount_ff <= csr_wdata[ldv_pkg::KCOUNT_W-1:0];
            ldv_pkg::CSR_RED_OFFSET:  roff_ff   <= csr_wdata;
            ldv_pkg::CSR_RED_SLOPE:   rslope_ff <= csr_wdata;
            ldv_pkg::CSR_BLUE_OFFSET: boff_ff   <= csr_wdata;
            ldv_pkg::CSR_BLUE_SLOPE:  bslope_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Knot count clamped to the table, as the last knot index.
   always_comb begin
      int nc;
      nc = int'(kcount_ff);
      if (nc < ldv_pkg::KCOUNT_MIN) begin
         nc = ldv_pkg::KCOUNT_MIN;
      end
      if (nc > ldv_pkg::MAX_KNOTS) begin
         nc = ldv_pkg::MAX_KNOTS;
      end
      nm1 = AW'(nc - 1);
   end

   assign front_cfg  = '{hshift: hshift_ff, tan_scale_x: tsx_ff, tan_scale_y: tsy_ff};
   assign chroma_cfg = '{red_offset: roff_ff, red_slope: rslope_ff,
                         blue_offset: boff_ff, blue_slope: bslope_ff};

   ldv_tangent u_tangent (
      .clock(clock), .reset(reset), .cfg(front_cfg),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tuser[0]), .in_eye(req_tdata[0]),
      .in_u(req_tdata[24:1]), .in_v(req_tdata[48:25]),
      .in_kidx(req_tdata[52:49]), .in_kval(req_tdata[76:53]),
      .out_valid(tan_valid), .out_ready(tan_ready), .out_item(tan_item));

   ldv_spline u_spline (
      .clock(clock), .reset(reset), .nm1(nm1),
      .in_valid(tan_valid), .in_ready(tan_ready), .in_item(tan_item),
      .out_valid(scale_valid), .out_ready(scale_ready), .out_item(scale_item));

   ldv_chroma u_chroma (
      .clock(clock), .reset(reset), .cfg(chroma_cfg),
      .in_valid(scale_valid), .in_ready(scale_ready), .in_item(scale_item),
      .out_valid(chan_valid), .out_ready(chan_ready), .out_item(chan_item));

   // Output stages: products, then the rounded result register.
   always_comb begin
      en[NS+1] = rsp_tready;
      for (int i = NS; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      for (int i = 1; i <= NS; i++) begin
         if (en[i]) begin
            v_in[i] = (i == 1) ? chan_valid : v_ff[i-1];
         end else begin
            v_in[i] = v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Channel scale times each tangent.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff[0] <= 48'(chan_item.cs_red)   * 48'(chan_item.tx);
         prod_ff[1] <= 48'(chan_item.cs_red)   * 48'(chan_item.ty);
         prod_ff[2] <= 48'(chan_item.cs_green) * 48'(chan_item.tx);
         prod_ff[3] <= 48'(chan_item.cs_green) * 48'(chan_item.ty);
         prod_ff[4] <= 48'(chan_item.cs_blue)  * 48'(chan_item.tx);
         prod_ff[5] <= 48'(chan_item.cs_blue)  * 48'(chan_item.ty);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 6; i++) begin
            res_ff[i] <= ldv_pkg::sat24(ldv_pkg::rnd16(64'(prod_ff[i])));
         end
      end
   end

   assign chan_ready = en[1];
   assign rsp_tvalid = v_ff[NS];
   assign rsp_tdata  = {res_ff[5], res_ff[4], res_ff[3], res_ff[2], res_ff[1], res_ff[0]};

endmodule

// ===== sv/ldv_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ldv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ldv_tangent.sv =====
// Front end: lens shift, tangent mapping and squared radius, five register stages.
// Depends on ldv_pkg.
`timescale 1ns / 1ps

module ldv_tangent (
   input  logic                   clock,
   input  logic                   reset,
   input  ldv_pkg::front_cfg_type cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_op,
   input  logic                   in_eye,
   input  ldv_pkg::q16_type       in_u,
   input  ldv_pkg::q16_type       in_v,
   input  logic [ldv_pkg::KNOT_AW-1:0] in_kidx,
   input  ldv_pkg::q16_type       in_kval,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ldv_pkg::tan_item_type  out_item
);

   localparam int NS = 5;

   logic [NS:1]   v_ff;
   logic [NS:1]   v_in;
   logic [NS+1:1] en;

   ldv_pkg::knot_cmd_type cmd_ff [NS:1];

   logic signed [26:0] a1_ff;
   logic signed [25:0] b1_ff;
   logic signed [50:0] pa2_ff;
   logic signed [49:0] pb2_ff;
   ldv_pkg::q16_type   tx3_ff, ty3_ff, tx4_ff, ty4_ff, tx5_ff, ty5_ff;
   logic signed [47:0] qx4_ff, qy4_ff;
   ldv_pkg::q16_type   rsq5_ff;
   logic signed [24:0] shift_in;

   // Stage enables: a stage moves when it is empty or its successor moves.
   always_comb begin
      en[NS+1] = out_ready;
      for (int i = NS; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      for (int i = 1; i <= NS; i++) begin
         if (en[i]) begin
            v_in[i] = (i == 1) ? in_valid : v_ff[i-1];
         end else begin
            v_in[i] = v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Knot commands ride along unchanged.
   always_ff @(posedge clock) begin
      for (int i = 1; i <= NS; i++) begin
         if (en[i]) begin
            if (i == 1) begin
               cmd_ff[i] <= '{op: in_op, kidx: in_kidx, kval: in_kval};
            end else begin
               cmd_ff[i] <= cmd_ff[i-1];
            end
         end
      end
   end

   // The shift is negated for the second eye, kept exact in 25 bits.
   assign shift_in = in_eye ? -25'(cfg.hshift) : 25'(cfg.hshift);

   // Stage 1: centered and doubled coordinates.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         a1_ff <= 27'(27'(shift_in) + 27'(in_u)) * 27'sd2 - 27'sd65536;
         b1_ff <= 26'(in_v) * 26'sd2 - 26'sd65536;
      end
   end

   // Stage 2: tangent scale products.
   always_ff @(posedge clock) begin
      if (en[2]) begin
         pa2_ff <= 51'(a1_ff) * 51'(cfg.tan_scale_x);
         pb2_ff <= 50'(b1_ff) * 50'(cfg.tan_scale_y);
      end
   end

   // Stage 3: round and saturate the tangents.
   always_ff @(posedge clock) begin
      if (en[3]) begin
         tx3_ff <= ldv_pkg::sat24(ldv_pkg::rnd16(64'(pa2_ff)));
         ty3_ff <= ldv_pkg::sat24(ldv_pkg::rnd16(64'(pb2_ff)));
      end
   end

   // Stage 4: squares.
   always_ff @(posedge clock) begin
      if (en[4]) begin
         qx4_ff <= 48'(tx3_ff) * 48'(tx3_ff);
         qy4_ff <= 48'(ty3_ff) * 48'(ty3_ff);
         tx4_ff <= tx3_ff;
         ty4_ff <= ty3_ff;
      end
   end

   // Stage 5: squared radius.
   always_ff @(posedge clock) begin
      if (en[5]) begin
         rsq5_ff <= ldv_pkg::sat24(ldv_pkg::rnd16(64'(qx4_ff) + 64'(qy4_ff)));
         tx5_ff  <= tx4_ff;
         ty5_ff  <= ty4_ff;
      end
   end

   assign in_ready  = en[1];
   assign out_valid = v_ff[NS];
   assign out_item  = '{cmd: cmd_ff[NS], crd: '{tx: tx5_ff, ty: ty5_ff, rsq: rsq5_ff}};

   // The squared radius of an evaluated vertex is never negative.
   a_rsq_nonneg: assert property (@(posedge clock) disable iff (reset)
      v_ff[5] && !cmd_ff[5].op |-> !rsq5_ff[23])
      else $error("negative squared radius");

endmodule

// ===== sv/ldv_spline.sv =====
// Catmull-Rom radial scale: segment search, knot fetch, Hermite weights and sum, a straight line past the last knot.
// Depends on ldv_pkg and ldv_ram (four copies of the knot table).
`timescale 1ns / 1ps

module ldv_spline (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ldv_pkg::KNOT_AW-1:0] nm1,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ldv_pkg::tan_item_type       in_item,
   output logic                        out_valid,
   input  logic                        out_ready,
   output ldv_pkg::scale_item_type     out_item
);

   localparam int NS  = 7;
   localparam int AW  = ldv_pkg::KNOT_AW;
   localparam int X_W = 23 + AW;
   localparam int KR_W = X_W - 16;
   localparam int LIN_W = 25 + X_W + 1;

   logic [NS:1]   v_ff;
   logic [NS:1]   v_in;
   logic [NS+1:1] en;

   ldv_pkg::coord_type crd_ff [NS:1];

   ldv_pkg::knot_cmd_type cmd1_ff, cmd2_ff;
   logic [X_W-1:0]  x1_ff;
   logic [KR_W-1:0] kraw;
   logic [AW-1:0]   k_in;
   logic [AW-1:0]   k2_ff;
   logic [X_W-1:0]  t2_ff, t3_ff, t4_ff;
   logic            last2_ff, first2_ff, lastin2_ff;
   logic            last3_ff, first3_ff, lastin3_ff;
   logic [31:0]     sq3_ff, sq4_ff;
   logic [47:0]     cube4_ff;
   logic [23:0]     q0, q1, q2, q3;
   logic signed [24:0] m0_in, m1_in;
   logic signed [24:0] m0_4_ff, m1_4_ff, m0_5_ff, m1_5_ff;
   ldv_pkg::q16_type p0_4_ff, p1_4_ff, p0_5_ff, p1_5_ff, p0_6_ff;
   logic            last4_ff, last5_ff, last6_ff;
   logic signed [17:0] h00_ff, h10_ff, h01_ff, h11_ff;
   logic signed [LIN_W-1:0] lin5_ff, lin6_ff;
   logic signed [42:0] pr0_ff, pr1_ff, pr2_ff, pr3_ff;
   ldv_pkg::q16_type scale7_ff;
   logic signed [63:0] t3s, t2s, t1s;
   logic            wr_en;

   // Stage enables; knot writes stop after stage 2.
   always_comb begin
      en[NS+1] = out_ready;
      for (int i = NS; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      for (int i = 1; i <= NS; i++) begin
         if (!en[i]) begin
            v_in[i] = v_ff[i];
         end else if (i == 1) begin
            v_in[i] = in_valid;
         end else if (i == 3) begin
            v_in[i] = v_ff[2] && !cmd2_ff.op;
         end else begin
            v_in[i] = v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Coordinates ride along.
   always_ff @(posedge clock) begin
      for (int i = 1; i <= NS; i++) begin
         if (en[i]) begin
            crd_ff[i] <= (i == 1) ? in_item.crd : crd_ff[i-1];
         end
      end
   end

   // Stage 1: spline abscissa.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         x1_ff   <= X_W'(nm1) * X_W'(in_item.crd.rsq[22:0]);
         cmd1_ff <= in_item.cmd;
      end
   end

   // Stage 2: segment index, clamped to the last knot, and its fraction.
   assign kraw = x1_ff[X_W-1:16];
   assign k_in = (kraw > KR_W'(nm1)) ? nm1 : kraw[AW-1:0];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         k2_ff      <= k_in;
         t2_ff      <= x1_ff - (X_W'(k_in) << 16);
         last2_ff   <= (k_in == nm1);
         first2_ff  <= (k_in == '0);
         lastin2_ff <= (k_in == nm1 - AW'(1));
         cmd2_ff    <= cmd1_ff;
      end
   end

   // Knot table copies, one per neighbor; a write lands as it leaves stage 2.
   assign wr_en = v_ff[2] && cmd2_ff.op && en[3];

   ldv_ram #(.WIDTH(24), .DEPTH(ldv_pkg::MAX_KNOTS)) u_ram_km1 (
      .clock(clock), .wr_en(wr_en), .wr_addr(cmd2_ff.kidx), .wr_data(cmd2_ff.kval),
      .rd_en(en[3]), .rd_addr(k2_ff - AW'(1)), .rd_data(q0));
   ldv_ram #(.WIDTH(24), .DEPTH(ldv_pkg::MAX_KNOTS)) u_ram_k0 (
      .clock(clock), .wr_en(wr_en), .wr_addr(cmd2_ff.kidx), .wr_data(cmd2_ff.kval),
      .rd_en(en[3]), .rd_addr(k2_ff), .rd_data(q1));
   ldv_ram #(.WIDTH(24), .DEPTH(ldv_pkg::MAX_KNOTS)) u_ram_kp1 (
      .clock(clock), .wr_en(wr_en), .wr_addr(cmd2_ff.kidx), .wr_data(cmd2_ff.kval),
      .rd_en(en[3]), .rd_addr(k2_ff + AW'(1)), .rd_data(q2));
   ldv_ram #(.WIDTH(24), .DEPTH(ldv_pkg::MAX_KNOTS)) u_ram_kp2 (
      .clock(clock), .wr_en(wr_en), .wr_addr(cmd2_ff.kidx), .wr_data(cmd2_ff.kval),
      .rd_en(en[3]), .rd_addr(k2_ff + AW'(2)), .rd_data(q3));

   // Stage 3: fraction squared, knots arrive from the tables.
   always_ff @(posedge clock) begin
      if (en[3]) begin
         sq3_ff     <= 32'(t2_ff[15:0]) * 32'(t2_ff[15:0]);
         t3_ff      <= t2_ff;
         last3_ff   <= last2_ff;
         first3_ff  <= first2_ff;
         lastin3_ff <= lastin2_ff;
      end
   end

   // Tangents; the first segment takes priority over the last inner one.
   always_comb begin
      priority if (last3_ff || first3_ff) begin
         m0_in = (last3_ff) ? 25'(signed'(q1)) - 25'(signed'(q0))
                            : 25'(signed'(q2)) - 25'(signed'(q1));
      end else begin
         m0_in = (25'(signed'(q2)) - 25'(signed'(q0))) >>> 1;
      end
      priority if (lastin3_ff && !first3_ff) begin
         m1_in = 25'(signed'(q2)) - 25'(signed'(q1));
      end else begin
         m1_in = (25'(signed'(q3)) - 25'(signed'(q1))) >>> 1;
      end
   end

   // Stage 4: fraction cubed and tangents.
   always_ff @(posedge clock) begin
      if (en[4]) begin
         cube4_ff <= 48'(sq3_ff) * 48'(t3_ff[15:0]);
         sq4_ff   <= sq3_ff;
         t4_ff    <= t3_ff;
         m0_4_ff  <= m0_in;
         m1_4_ff  <= m1_in;
         p0_4_ff  <= signed'(q1);
         p1_4_ff  <= signed'(q2);
         last4_ff <= last3_ff;
      end
   end

   // Stage 5: Hermite basis weights in Q16, and the extrapolation product.
   assign t3s = signed'(64'(cube4_ff));
   assign t2s = signed'(64'(sq4_ff)) <<< 16;
   assign t1s = signed'(64'(t4_ff[15:0])) <<< 32;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         h00_ff   <= 18'(ldv_pkg::rnd32(2 * t3s - 3 * t2s + (64'sd1 <<< 48)));
         h10_ff   <= 18'(ldv_pkg::rnd32(t3s - 2 * t2s + t1s));
         h01_ff   <= 18'(ldv_pkg::rnd32(3 * t2s - 2 * t3s));
         h11_ff   <= 18'(ldv_pkg::rnd32(t3s - t2s));
         lin5_ff  <= LIN_W'(m0_4_ff) * signed'({1'b0, t4_ff});
         m0_5_ff  <= m0_4_ff;
         m1_5_ff  <= m1_4_ff;
         p0_5_ff  <= p0_4_ff;
         p1_5_ff  <= p1_4_ff;
         last5_ff <= last4_ff;
      end
   end

   // Stage 6: weighted terms.
   always_ff @(posedge clock) begin
      if (en[6]) begin
         pr0_ff   <= 43'(p0_5_ff) * 43'(h00_ff);
         pr1_ff   <= 43'(m0_5_ff) * 43'(h10_ff);
         pr2_ff   <= 43'(p1_5_ff) * 43'(h01_ff);
         pr3_ff   <= 43'(m1_5_ff) * 43'(h11_ff);
         lin6_ff  <= lin5_ff;
         p0_6_ff  <= p0_5_ff;
         last6_ff <= last5_ff;
      end
   end

   // Stage 7: cubic sum, or the straight line past the last knot.
   always_ff @(posedge clock) begin
      if (en[7]) begin
         if (last6_ff) begin
            scale7_ff <= ldv_pkg::sat24(64'(p0_6_ff) + ldv_pkg::rnd16(64'(lin6_ff)));
         end else begin
            scale7_ff <= ldv_pkg::sat24(ldv_pkg::rnd16(64'(pr0_ff) + 64'(pr1_ff)
                                                      + 64'(pr2_ff) + 64'(pr3_ff)));
         end
      end
   end

   assign in_ready  = en[1];
   assign out_valid = v_ff[NS];
   assign out_item  = '{crd: crd_ff[NS], scale: scale7_ff};

   // The segment index never passes the last knot.
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && !cmd2_ff.op |-> k2_ff <= nm1)
      else $error("segment index beyond last knot");

   // Inside the table the fraction stays below one.
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && !cmd2_ff.op && !last2_ff |-> t2_ff < X_W'(65536))
      else $error("segment fraction out of range");

   // Knot writes leave the pipeline at stage 2 and never reach the output.
   a_write_drop: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && cmd2_ff.op && en[3] |=> !v_ff[3])
      else $error("knot write passed the read stage");

endmodule

// ===== sv/ldv_chroma.sv =====
// Chromatic scale per channel: slope product, factor, scaled factor, four stages.
// Depends on ldv_pkg.
`timescale 1ns / 1ps

module ldv_chroma (
   input  logic                    clock,
   input  logic                    reset,
   input  ldv_pkg::chroma_cfg_type cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ldv_pkg::scale_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ldv_pkg::chan_item_type  out_item
);

   localparam int NS = 4;

   logic [NS:1]   v_ff;
   logic [NS:1]   v_in;
   logic [NS+1:1] en;

   ldv_pkg::q16_type tx_ff [NS:1];
   ldv_pkg::q16_type ty_ff [NS:1];
   ldv_pkg::q16_type sc_ff [NS:1];

   ldv_pkg::q16_type   rsq1_ff;
   logic signed [47:0] pr1_ff, pb1_ff, mr3_ff, mb3_ff;
   ldv_pkg::q16_type   fr2_ff, fb2_ff, csr4_ff, csb4_ff;

   // Stage enables.
   always_comb begin
      en[NS+1] = out_ready;
      for (int i = NS; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      for (int i = 1; i <= NS; i++) begin
         if (en[i]) begin
            v_in[i] = (i == 1) ? in_valid : v_ff[i-1];
         end else begin
            v_in[i] = v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Tangents and the green scale ride along.
   always_ff @(posedge clock) begin
      for (int i = 1; i <= NS; i++) begin
         if (en[i]) begin
            tx_ff[i] <= (i == 1) ? in_item.crd.tx : tx_ff[i-1];
            ty_ff[i] <= (i == 1) ? in_item.crd.ty : ty_ff[i-1];
            sc_ff[i] <= (i == 1) ? in_item.scale : sc_ff[i-1];
         end
      end
   end

   // Stage 1: radius-dependent chromatic products.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         pr1_ff  <= 48'(in_item.crd.rsq) * 48'(cfg.red_slope);
         pb1_ff  <= 48'(in_item.crd.rsq) * 48'(cfg.blue_slope);
         rsq1_ff <= in_item.crd.rsq;
      end
   end

   // Stage 2: channel factors around one.
   always_ff @(posedge clock) begin
      if (en[2]) begin
         fr2_ff <= ldv_pkg::sat24(64'sd65536 + 64'(cfg.red_offset)
                   + 64'(ldv_pkg::sat24(ldv_pkg::rnd16(64'(pr1_ff)))));
         fb2_ff <= ldv_pkg::sat24(64'sd65536 + 64'(cfg.blue_offset)
                   + 64'(ldv_pkg::sat24(ldv_pkg::rnd16(64'(pb1_ff)))));
      end
   end

   // Stage 3: factors times the radial scale.
   always_ff @(posedge clock) begin
      if (en[3]) begin
         mr3_ff <= 48'(sc_ff[2]) * 48'(fr2_ff);
         mb3_ff <= 48'(sc_ff[2]) * 48'(fb2_ff);
      end
   end

   // Stage 4: channel scales.
   always_ff @(posedge clock) begin
      if (en[4]) begin
         csr4_ff <= ldv_pkg::sat24(ldv_pkg::rnd16(64'(mr3_ff)));
         csb4_ff <= ldv_pkg::sat24(ldv_pkg::rnd16(64'(mb3_ff)));
      end
   end

   assign in_ready  = en[1];
   assign out_valid = v_ff[NS];
   assign out_item  = '{tx: tx_ff[NS], ty: ty_ff[NS], cs_red: csr4_ff,
                        cs_green: sc_ff[NS], cs_blue: csb4_ff};

   // A zero slope leaves the factor independent of the radius.
   a_flat_slope: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] && cfg.red_slope == '0 |-> pr1_ff == '0 || rsq1_ff != rsq1_ff)
      else $error("red slope product nonzero at zero slope");

endmodule
